// ===== sv/sc2a_pkg.sv =====
package sc2a_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned MAP_LEN = 58;

  localparam logic [CODE_W-1:0] RELEASE_BIT = 8'h80;
  localparam logic [6:0]        CODE_MASK   = 7'h7F;

  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam logic [6:0] KEY_BKSP   = 7'h0E;
  localparam logic [6:0] KEY_ENTER  = 7'h1C;
  localparam logic [6:0] KEY_SPACE  = 7'h39;

  localparam logic [CHAR_W-1:0] CHR_BKSP  = 7'h08;
  localparam logic [CHAR_W-1:0] CHR_ENTER = 7'h0A;
  localparam logic [CHAR_W-1:0] CHR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHR_A_LO  = 7'h61;
  localparam logic [CHAR_W-1:0] CHR_Z_LO  = 7'h7A;

  typedef struct packed {
    logic shift_held;
    logic caps_on;
  } sc2a_mods_t;

  // Main key block, codes 0 to 57; entries 58 to 63 pad the index range.
  localparam logic [CHAR_W-1:0] LOWER_MAP [64] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CHAR_W-1:0] UPPER_MAP [64] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

// ===== sv/scancode_to_ascii_translator_unit.sv =====
// Channel | Handshake           | Payload
// in      | in_valid / in_ready | scan_code[7:0]
// out     | out_valid/out_ready | ascii_char[6:0], char_valid
//
// One item per cycle sustained while out_ready stays high; each item passes
// through an input register, then the table lookup into the result register.
// Shift and caps flags update as an item moves into the result register, so
// items see them in order.
// Reset clears both flags and both stage valids.
// A stalled result holds; the input register can still take one more item if empty.
module scancode_to_ascii_translator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sc2a_pkg::CODE_W-1:0] scan_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sc2a_pkg::CHAR_W-1:0] ascii_char,
  output logic                        char_valid
);
  import sc2a_pkg::*;

  logic              code_valid;
  logic [CODE_W-1:0] code;
  sc2a_mods_t        mods;
  sc2a_mods_t        mods_next;
  logic [CHAR_W-1:0] ascii_next;
  logic              advance;

  assign advance  = code_valid && (!out_valid || out_ready);
  assign in_ready = !code_valid || advance;

  sc2a_xlat u_xlat (
    .code      (code),
    .mods      (mods),
    .ascii     (ascii_next),
    .mods_next (mods_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (in_ready) begin
      code_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code <= scan_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mods      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        mods      <= mods_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ascii_char <= ascii_next;
      char_valid <= (ascii_next != '0);
    end
  end

endmodule

// ===== sv/sc2a_xlat.sv =====
module sc2a_xlat (
  input  logic [sc2a_pkg::CODE_W-1:0] code,
  input  sc2a_pkg::sc2a_mods_t        mods,
  output logic [sc2a_pkg::CHAR_W-1:0] ascii,
  output sc2a_pkg::sc2a_mods_t        mods_next
);
  import sc2a_pkg::*;

  logic [6:0]        key;
  logic [5:0]        idx;
  logic              in_map;
  logic [CHAR_W-1:0] base;
  logic [CHAR_W-1:0] upper;
  logic              use_upper;

  assign key    = code[6:0] & CODE_MASK;
  assign idx    = key[5:0];
  assign in_map = (key < 7'(MAP_LEN));
  assign base   = LOWER_MAP[idx];
  assign upper  = UPPER_MAP[idx];

  always_comb begin
    if (base inside {[CHR_A_LO:CHR_Z_LO]}) begin
      use_upper = mods.shift_held ^ mods.caps_on;
    end else begin
      use_upper = mods.shift_held;
    end
  end

  always_comb begin
    mods_next = mods;
    ascii     = '0;
    if ((code & RELEASE_BIT) != '0) begin
      // release: only shift keys matter, prefix bytes fall through here too
      if (key inside {KEY_LSHIFT, KEY_RSHIFT}) begin
        mods_next.shift_held = 1'b0;
      end
    end else begin
      case (key)
        KEY_LSHIFT, KEY_RSHIFT: mods_next.shift_held = 1'b1;
        KEY_CAPS:               mods_next.caps_on    = ~mods.caps_on;
        KEY_BKSP:               ascii = CHR_BKSP;
        KEY_ENTER:              ascii = CHR_ENTER;
        KEY_SPACE:              ascii = CHR_SPACE;
        default: begin
          if (in_map) begin
            ascii = use_upper ? upper : base;
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/sc2a_checker.sv =====
module sc2a_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sc2a_pkg::CHAR_W-1:0] ascii_char,
  input logic                        char_valid
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(char_valid))
    else $error("result changed while stalled");

  a_flag_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_valid == (ascii_char != '0)))
    else $error("char_valid disagrees with ascii_char");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // with the result side empty the input side must take an item
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

endmodule

bind scancode_to_ascii_translator_unit sc2a_checker u_sc2a_checker (.*);
